@@ hdl/adcsl_pkg.sv @@
// Shared types and constants for the converter scan channel list.
package adcsl_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int IDX_W        = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

  localparam int KIND_W = 2;
  localparam int CH_W   = 3;
  localparam int ST_W   = 3;
  localparam int LCNT_W = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESULT
  } state_e;

endpackage

@@ hdl/adcsl_if.sv @@
// Request and response channel interfaces of the scan channel list.
interface adcsl_req_if import adcsl_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_e             kind;
  logic [CH_W-1:0]   channel_id;
  logic [CH_W-1:0]   slot;

  modport source (output valid, kind, channel_id, slot, input ready);
  modport sink   (input valid, kind, channel_id, slot, output ready);
endinterface

interface adcsl_rsp_if import adcsl_pkg::*; ();
  logic              valid;
  logic              ready;
  status_e           status;
  logic              present;
  logic [CH_W-1:0]   found_slot;
  logic [CH_W-1:0]   slot_channel;
  logic [LCNT_W-1:0] list_count;

  modport source (output valid, status, present, found_slot, slot_channel, list_count,
                  input ready);
  modport sink   (input valid, status, present, found_slot, slot_channel, list_count,
                  output ready);
endinterface

@@ hdl/adc_scan_channel_list_top.sv @@
// Scan channel list top level: keeps an ordered list of converter channels in one RAM and
// the channel-to-position map in a second RAM with valid flags in flops, cleared at reset.
// One request word is handled at a time. A remove walks the scan list RAM one entry at a
// time for each entry behind the removed one: a read state, then a write state that puts
// the entry back one position lower along with the moved channel's new map position.
// A new request is taken while the previous response word still waits in the output
// register.
module adc_scan_channel_list_top import adcsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  adcsl_req_if.sink   req_i,
  adcsl_rsp_if.source rsp_o
);

  state_e state_q, state_d;

  kind_e             kind_q;
  logic [CH_W-1:0]   ch_q;
  logic [CH_W-1:0]   slot_q;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [MAX_CHANNELS-1:0] valid_q, valid_d;

  status_e           res_status_q, res_status_d;
  logic              res_present_q, res_present_d;
  logic [CH_W-1:0]   res_found_q, res_found_d;
  logic [CH_W-1:0]   res_slot_ch_q, res_slot_ch_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_present_q;
  logic [CH_W-1:0]   out_found_q;
  logic [CH_W-1:0]   out_slot_ch_q;
  logic [LCNT_W-1:0] out_count_q;

  logic              req_acc;
  logic              rsp_load;
  logic [IDX_W-1:0]  ch_addr;
  logic              ch_ok;
  logic              ch_valid;
  logic              lk_add;
  logic              lk_remove;
  logic [CNT_W-1:0]  rm_next;
  logic              rm_shift;
  logic [CNT_W-1:0]  idx_inc;
  logic              shift_more;

  logic              scan_we;
  logic [IDX_W-1:0]  scan_waddr;
  logic [CH_W-1:0]   scan_wdata;
  logic [IDX_W-1:0]  scan_raddr;
  logic [CH_W-1:0]   scan_rdata;
  logic              pos_we;
  logic [IDX_W-1:0]  pos_waddr;
  logic [IDX_W-1:0]  pos_wdata;
  logic [IDX_W-1:0]  pos_raddr;
  logic [IDX_W-1:0]  pos_rdata;

  assign req_acc  = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == S_RESULT) && (!out_valid_q || rsp_o.ready);

  assign ch_addr    = IDX_W'(ch_q);
  assign ch_ok      = int'(ch_q) < MAX_CHANNELS;
  assign ch_valid   = valid_q[ch_addr];
  assign rm_next    = CNT_W'(pos_rdata) + CNT_W'(1);
  assign rm_shift   = rm_next < count_q;
  assign idx_inc    = idx_q + CNT_W'(1);
  assign shift_more = idx_inc < count_q;

  // Lookup decode and result selection
  always_comb begin
    res_status_d  = res_status_q;
    res_present_d = res_present_q;
    res_found_d   = res_found_q;
    res_slot_ch_d = res_slot_ch_q;
    lk_add        = 1'b0;
    lk_remove     = 1'b0;
    if (state_q == S_LOOKUP) begin
      res_status_d  = ST_OK;
      res_present_d = 1'b0;
      res_found_d   = '0;
      res_slot_ch_d = '0;
      if (kind_q == KIND_READ) begin
        if (int'(slot_q) >= int'(count_q) || int'(slot_q) >= MAX_CHANNELS) begin
          res_status_d = ST_RANGE;
        end else begin
          res_present_d = 1'b1;
          res_found_d   = slot_q;
          res_slot_ch_d = scan_rdata;
        end
      end else if (!ch_ok) begin
        res_status_d = ST_RANGE;
      end else begin
        case (kind_q)
          KIND_ADD: begin
            if (ch_valid) begin
              res_status_d  = ST_DUP;
              res_present_d = 1'b1;
              res_found_d   = CH_W'(pos_rdata);
            end else if (int'(count_q) >= MAX_CHANNELS) begin
              res_status_d = ST_FULL;
            end else begin
              lk_add        = 1'b1;
              res_present_d = 1'b1;
              res_found_d   = CH_W'(count_q);
            end
          end
          KIND_REMOVE: begin
            if (ch_valid) begin
              lk_remove   = 1'b1;
              res_found_d = CH_W'(pos_rdata);
            end else begin
              res_status_d = ST_ABSENT;
            end
          end
          KIND_FIND: begin
            if (ch_valid) begin
              res_present_d = 1'b1;
              res_found_d   = CH_W'(pos_rdata);
            end else begin
              res_status_d = ST_ABSENT;
            end
          end
          default: begin
            res_status_d = ST_RANGE;
          end
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (lk_remove && rm_shift) state_d = S_SHIFT_RD;
        else state_d = S_RESULT;
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        if (shift_more) state_d = S_SHIFT_RD;
        else state_d = S_RESULT;
      end
      S_RESULT: begin
        if (rsp_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State updates and memory controls
  always_comb begin
    idx_d      = idx_q;
    count_d    = count_q;
    valid_d    = valid_q;
    scan_we    = 1'b0;
    scan_waddr = IDX_W'(count_q);
    scan_wdata = ch_q;
    pos_we     = 1'b0;
    pos_waddr  = ch_addr;
    pos_wdata  = IDX_W'(count_q);
    scan_raddr = IDX_W'(req_i.slot);
    pos_raddr  = IDX_W'(req_i.channel_id);
    case (state_q)
      S_LOOKUP: begin
        if (lk_add) begin
          scan_we          = 1'b1;
          pos_we           = 1'b1;
          valid_d[ch_addr] = 1'b1;
          count_d          = count_q + CNT_W'(1);
        end
        if (lk_remove) begin
          valid_d[ch_addr] = 1'b0;
          idx_d            = rm_next;
          if (!rm_shift) count_d = count_q - CNT_W'(1);
        end
      end
      S_SHIFT_RD: begin
        scan_raddr = idx_q[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        scan_we    = 1'b1;
        scan_waddr = IDX_W'(idx_q - CNT_W'(1));
        scan_wdata = scan_rdata;
        pos_we     = 1'b1;
        pos_waddr  = IDX_W'(scan_rdata);
        pos_wdata  = IDX_W'(idx_q - CNT_W'(1));
        idx_d      = idx_inc;
        if (!shift_more) count_d = count_q - CNT_W'(1);
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
      if (rsp_load) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      kind_q <= req_i.kind;
      ch_q   <= req_i.channel_id;
      slot_q <= req_i.slot;
    end
    idx_q         <= idx_d;
    res_status_q  <= res_status_d;
    res_present_q <= res_present_d;
    res_found_q   <= res_found_d;
    res_slot_ch_q <= res_slot_ch_d;
    if (rsp_load) begin
      out_status_q  <= res_status_q;
      out_present_q <= res_present_q;
      out_found_q   <= res_found_q;
      out_slot_ch_q <= res_slot_ch_q;
      out_count_q   <= LCNT_W'(count_q);
    end
  end

  adcsl_ram #(
    .WIDTH (CH_W),
    .DEPTH (MAX_CHANNELS)
  ) u_scan_ram (
    .clk_i   (clk_i),
    .we_i    (scan_we),
    .waddr_i (scan_waddr),
    .wdata_i (scan_wdata),
    .raddr_i (scan_raddr),
    .rdata_o (scan_rdata)
  );

  adcsl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_CHANNELS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.present      = out_present_q;
  assign rsp_o.found_slot   = out_found_q;
  assign rsp_o.slot_channel = out_slot_ch_q;
  assign rsp_o.list_count   = out_count_q;

endmodule

@@ hdl/adcsl_ram.sv @@
// Generic single write port RAM with registered read.
module adcsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
